// ----- rtl/bms_pkg.sv -----
// ----------------------------------------------------------------------------
// Block RMS meter package
// Shared constants, register indexes and control types of the RMS meter.
// ----------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

  localparam int unsigned ADC_W     = 32;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned SQ_W      = 32;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned RMS_W     = 16;
  localparam int unsigned DC_W      = 16;
  localparam int unsigned BLK_W     = 24;
  localparam int unsigned SHIFT_W   = 6;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned COUNT_BITS_DEF = 24;

  localparam logic [DC_W-1:0]    DC_RESET    = 16'd32768;
  localparam logic [BLK_W-1:0]   BLK_RESET   = 24'd1024;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd10;

  localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_SHIFT    = 2'd2;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_sts_t;

endpackage

`default_nettype wire

// ----- rtl/bms_stream_if.sv -----
// ----------------------------------------------------------------------------
// Block RMS meter stream interfaces
// Valid/ready channels for ADC words in and RMS values out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bms_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] adc_word;

  modport source (output valid, output adc_word, input ready);
  modport sink (input valid, input adc_word, output ready);
endinterface

interface bms_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rms_value;

  modport source (output valid, output rms_value, input ready);
  modport sink (input valid, input rms_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/bms_acc.sv -----
// ----------------------------------------------------------------------------
// Block RMS meter accumulator
// Squares one sample, adds it to the 64-bit sum and counts down the block, or clears the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_acc import bms_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire acc_ctrl_t               ctrl_i,
  input  wire logic signed [SMP_W-1:0] sample_i,
  input  wire logic [BLK_W-1:0]        blk_len_i,
  output logic [SUM_W-1:0]             sum_o,
  output logic                         last_o
);

  logic signed [SQ_W-1:0]  square;
  logic [SUM_W-1:0]        sum_d, sum_q;
  logic [COUNT_BITS-1:0]   cnt_d, cnt_q;

  assign square = SQ_W'(sample_i) * SQ_W'(sample_i);
  assign last_o = (cnt_q <= COUNT_BITS'(1));

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.add) begin
      sum_d = sum_q + {{(SUM_W-SQ_W){1'b0}}, $unsigned(square)};
      if (last_o) begin
        cnt_d = COUNT_BITS'(blk_len_i);
      end else begin
        cnt_d = cnt_q - COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= COUNT_BITS'(BLK_RESET);
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ----- rtl/bms_sqrt.sv -----
// ----------------------------------------------------------------------------
// Block RMS meter square root unit
// Floor square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_sqrt import bms_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SQ_W-1:0]  radicand_i,
  output sqrt_sts_t             sts_o,
  output logic [RMS_W-1:0]      root_o
);

  localparam int unsigned REM_W = RMS_W + 2;
  localparam int unsigned CNT_W = $clog2(RMS_W);

  logic [SQ_W-1:0]    rad_d, rad_q;
  logic [REM_W-1:0]   rem_d, rem_q;
  logic [RMS_W-1:0]   root_d, root_q;
  logic [CNT_W-1:0]   cnt_d, cnt_q;
  logic               busy_d, busy_q;
  logic               done_d, done_q;
  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic               fits;

  assign rem_sh = {rem_q, rad_q[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[SQ_W-3:0], 2'b00};
      rem_d  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_d = {root_q[RMS_W-2:0], fits};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(RMS_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;

endmodule

`default_nettype wire

// ----- rtl/block_rms_meter.sv -----
// ----------------------------------------------------------------------------
// Block RMS meter
// Sums squares of DC-corrected ADC samples and reports the block RMS value.
// ----------------------------------------------------------------------------
// Channel    Dir  Payload          Width
// sample_i   in   adc_word         32
// result_o   out  rms_value        16
// cfg        in   cfg_wdata_i      24 (index cfg_idx_i)
//
// A sample that does not end a block passes through request and accumulate.
// A sample that ends a block also passes through shift, root and output,
// waiting in root on the one-bit-per-cycle square root unit.
// The finished value waits in the output register; a new sample is taken
// meanwhile unless a further block ends before the value is taken.
// Reset restores the register defaults, clears the sum and loads the counter.
// ----------------------------------------------------------------------------
`default_nettype none

module block_rms_meter import bms_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  bms_in_if.sink                    sample_i,
  bms_out_if.source                 result_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]           state_d, state_q;
  logic [DC_W-1:0]      dc_q;
  logic [BLK_W-1:0]     blk_q;
  logic [SHIFT_W-1:0]   shift_q;
  logic [SMP_W-1:0]     smp_q;
  logic [SUM_W-1:0]     sum;
  logic                 last;
  acc_ctrl_t            acc_ctrl;
  sqrt_sts_t            sqrt_sts;
  logic                 sqrt_start;
  logic [SQ_W-1:0]      avg;
  logic [RMS_W-1:0]     root;
  logic                 out_valid_d, out_valid_q;
  logic [RMS_W-1:0]     rms_q;
  logic                 in_req;
  logic                 out_load;

  assign sample_i.ready = (state_q == S_IDLE);
  assign in_req         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q    <= DC_RESET;
      blk_q   <= BLK_RESET;
      shift_q <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DC_OFFSET:    dc_q    <= cfg_wdata_i[DC_W-1:0];
        REG_BLOCK_LENGTH: blk_q   <= cfg_wdata_i[BLK_W-1:0];
        REG_AVG_SHIFT:    shift_q <= cfg_wdata_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      smp_q <= sample_i.adc_word[SMP_W-1:0] - dc_q;
    end
  end

  assign avg = SQ_W'(sum >> shift_q);

  always_comb begin
    state_d        = state_q;
    acc_ctrl.add   = 1'b0;
    acc_ctrl.clear = 1'b0;
    sqrt_start     = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_req) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        acc_ctrl.add = 1'b1;
        state_d      = last ? S_SHIFT : S_IDLE;
      end
      S_SHIFT: begin
        sqrt_start     = 1'b1;
        acc_ctrl.clear = 1'b1;
        state_d        = S_ROOT;
      end
      S_ROOT: begin
        if (sqrt_sts.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rms_q <= root;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.rms_value = rms_q;

  bms_acc #(
    .COUNT_BITS(COUNT_BITS)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .sample_i ($signed(smp_q)),
    .blk_len_i(blk_q),
    .sum_o    (sum),
    .last_o   (last)
  );

  bms_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .radicand_i(avg),
    .sts_o     (sqrt_sts),
    .root_o    (root)
  );

`ifndef SYNTHESIS
  a_req_to_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> (state_q == S_ACC))
    else $error("accepted sample did not move to accumulate");

  a_sqrt_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_sts.busy |-> (state_q == S_ROOT))
    else $error("square root unit busy outside root state");

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |=> (sum == '0))
    else $error("sum not cleared after block end");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> ($past(state_q) == S_OUT))
    else $error("result raised outside output state");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Block RMS meter testbench
// ADC words go into the sample channel, with random gaps on the input and
// random backpressure on the output. A model in the bench keeps its own copy
// of the registers, the sum of squares and the block counter, works out each
// RMS value when the sample that ends a block is accepted, and checks every result in order.
// The registers change only between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bms_pkg::*;

  localparam int unsigned CNT_W        = COUNT_BITS_DEF;
  localparam int unsigned SETTLE       = 24;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned MAX_SHOWN    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  bms_in_if  smp ();
  bms_out_if res ();

  block_rms_meter #(.COUNT_BITS(CNT_W)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (smp),
    .result_o    (res)
  );

  logic [ADC_W-1:0] adc_pending[$];
  logic [RMS_W-1:0] rms_expected[$];

  logic [DC_W-1:0]    dc_now;
  logic [BLK_W-1:0]   blk_len;
  logic [SHIFT_W-1:0] shift_now;
  logic [SUM_W-1:0]   sq_sum;
  logic [CNT_W-1:0]   left_in_block;

  int errors = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_writes = 0;
  int in_gap_max = 19;
  int out_gap_max = 19;
  bit hold_req = 1'b0;
  bit hold_taken;
  int send_gap;
  int recv_gap;
  int hold_left;
  int quiet;

  initial begin
    smp.valid = 1'b0;
    smp.adc_word = '0;
    res.ready = 1'b0;
  end

  always #4 clk = ~clk;

  task automatic accumulate_sample(input logic [ADC_W-1:0] word);
    logic [ADC_W-1:0]        diff;
    logic signed [SQ_W-1:0]  level;
    logic [SUM_W-1:0]        scaled;
    logic [31:0]             avg;
    logic [31:0]             root;
    logic [31:0]             trial;
    diff = word - ADC_W'(dc_now);
    level = $signed(diff[SMP_W-1:0]);
    sq_sum = sq_sum + SUM_W'(level * level);
    if (left_in_block <= 1) begin
      scaled = sq_sum >> shift_now;
      avg = scaled[31:0];
      root = '0;
      for (int b = 15; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (SUM_W'(trial) * SUM_W'(trial) <= SUM_W'(avg)) root = trial;
      end
      rms_expected.push_back(root[RMS_W-1:0]);
      sq_sum = '0;
      left_in_block = CNT_W'(blk_len);
    end else begin
      left_in_block = left_in_block - 1'b1;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin : monitor
    logic [RMS_W-1:0] want;
    if (!rst_n) begin
      dc_now = DC_RESET;
      blk_len = BLK_RESET;
      shift_now = SHIFT_RESET;
      sq_sum = '0;
      left_in_block = CNT_W'(BLK_RESET);
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_DC_OFFSET:    dc_now = cfg_wdata[DC_W-1:0];
          REG_BLOCK_LENGTH: blk_len = cfg_wdata[BLK_W-1:0];
          REG_AVG_SHIFT:    shift_now = cfg_wdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        accumulate_sample(smp.adc_word);
        n_samples++;
      end
      if (res.valid && res.ready) begin
        n_results++;
        if (rms_expected.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("ERROR: RMS result %0d with no request pending", res.rms_value);
        end else begin
          want = rms_expected.pop_front();
          if (res.rms_value !== want) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("ERROR: rms_value %0d, expected %0d", res.rms_value, want);
          end
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      smp.valid <= 1'b0;
      smp.adc_word <= '0;
      send_gap <= 0;
    end else if (!smp.valid || smp.ready) begin
      if (send_gap == 0 && adc_pending.size() != 0) begin
        smp.valid <= 1'b1;
        smp.adc_word <= adc_pending.pop_front();
        send_gap <= $urandom_range(0, in_gap_max);
      end else begin
        smp.valid <= 1'b0;
        if (send_gap != 0) send_gap <= send_gap - 1;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : receiver
    int draw;
    if (!rst_n) begin
      res.ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else if (res.ready) begin
      if (res.valid) begin
        draw = $urandom_range(0, out_gap_max);
        if (draw != 0) begin
          res.ready <= 1'b0;
          recv_gap <= draw - 1;
        end
      end
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [ADC_W-1:0] draw_word();
    logic [SMP_W-1:0] low;
    case ($urandom_range(0, 3))
      0:       low = dc_now + SMP_W'($urandom_range(0, 64)) - 16'd32;
      1:       low = dc_now + 16'h8000 + SMP_W'($urandom_range(0, 3));
      2:       low = dc_now + 16'h7FFF - SMP_W'($urandom_range(0, 3));
      default: low = SMP_W'($urandom);
    endcase
    return {16'($urandom), low};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_writes++;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [DC_W-1:0] dc, input logic [BLK_W-1:0] blk,
                              input logic [SHIFT_W-1:0] shift);
    write_reg(REG_DC_OFFSET, {(CFG_W-DC_W)'($urandom), dc});
    write_reg(REG_BLOCK_LENGTH, blk);
    write_reg(REG_AVG_SHIFT, {(CFG_W-SHIFT_W)'($urandom), shift});
  endtask

  // Waits until every word is sent and every RMS value is back, then lets
  // the longest block end run out before the registers may change.
  task automatic drain();
    @(negedge clk);
    while (adc_pending.size() != 0 || smp.valid || rms_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // The longest block length is only written while the block in progress
  // cannot end, so it is never loaded into the counter.
  task automatic long_block_phase();
    int k;
    program_regs(DC_W'($urandom), {BLK_W{1'b1}}, SHIFT_W'($urandom));
    k = (left_in_block > 1) ? int'(left_in_block) - 1 : 0;
    repeat (k) adc_pending.push_back(draw_word());
    drain();
  endtask

  initial begin : stimulus
    int n;
    int rnd;
    bit max_done;
    logic [DC_W-1:0]    dc_pick;
    logic [BLK_W-1:0]   len_pick;
    logic [SHIFT_W-1:0] sh_pick;
    max_done = 1'b0;
    rnd = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The first block runs at the reset length, so it starts with the extremes.
    adc_pending.push_back(32'h0000_0000);
    adc_pending.push_back(32'hFFFF_FFFF);
    adc_pending.push_back(32'h0000_8000);
    adc_pending.push_back(32'h0000_7FFF);
    adc_pending.push_back(32'hFFFF_0000);
    adc_pending.push_back(32'h0000_FFFF);
    adc_pending.push_back(32'h5A5A_8001);
    adc_pending.push_back(32'hA5A5_7FFE);
    while (adc_pending.size() < 1000) adc_pending.push_back(draw_word());
    drain();

    // A new length written in the middle of a block waits for the reload.
    write_reg(REG_BLOCK_LENGTH, 24'd1);
    write_reg(REG_UNUSED, CFG_W'($urandom));
    repeat (24) adc_pending.push_back(draw_word());
    drain();

    program_regs(16'd0, 24'd0, 6'd0);
    adc_pending.push_back(32'h0000_8000);
    adc_pending.push_back(32'h0000_7FFF);
    adc_pending.push_back(32'hFFFF_FFFF);
    adc_pending.push_back(32'h1234_0000);
    adc_pending.push_back(32'h0000_0001);
    drain();

    program_regs(16'hFFFF, 24'd2, 6'd63);
    adc_pending.push_back(32'h0000_FFFF);
    adc_pending.push_back(32'h0000_7FFF);
    adc_pending.push_back(32'hFFFF_0000);
    adc_pending.push_back(32'hFFFF_8000);
    drain();

    // Four full-scale squares add up to 2^32, which the 32-bit average truncates to zero.
    program_regs(16'd0, 24'd4, 6'd0);
    repeat (8) adc_pending.push_back(32'h0000_8000);
    drain();

    // Output held off while words keep coming, each word after the length-1 reload ending a block.
    program_regs(DC_W'($urandom), 24'd1, 6'd15);
    in_gap_max = 0;
    hold_req = 1'b1;
    repeat (40) adc_pending.push_back(draw_word());
    drain();
    in_gap_max = 19;

    while (rnd < RANDOM_ITEMS) begin
      if (!max_done && rnd >= 200 && left_in_block > 1) begin
        long_block_phase();
        max_done = 1'b1;
      end else begin
        case ($urandom_range(0, 4))
          0:       dc_pick = 16'd0;
          1:       dc_pick = 16'hFFFF;
          2:       dc_pick = 16'h8000;
          default: dc_pick = DC_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0:       len_pick = 24'd0;
          7, 8:    len_pick = BLK_W'($urandom_range(9, 40));
          9:       len_pick = 24'd1;
          default: len_pick = BLK_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 5))
          0:       sh_pick = 6'd0;
          1:       sh_pick = 6'd63;
          default: sh_pick = SHIFT_W'($urandom_range(0, 36));
        endcase
        program_regs(dc_pick, len_pick, sh_pick);
        in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
        out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
        n = $urandom_range(5, 40);
        repeat (n) adc_pending.push_back(draw_word());
        rnd += n;
        drain();
      end
    end
    if (!max_done) long_block_phase();

    drain();
    errors += rms_expected.size();
    $display("Checked %0d RMS values from %0d ADC words with %0d register writes.",
             n_results, n_samples, n_writes);
    $display("Lengths 0 to 16777215, shifts 0 to 63 and a %0d-cycle output hold-off were run.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bms_pkg.sv
rtl/bms_stream_if.sv
rtl/bms_acc.sv
rtl/bms_sqrt.sv
rtl/block_rms_meter.sv
bench/tb.sv
